### design/sblru_pkg.sv
`timescale 1ns / 1ps

package sblru_pkg;

    localparam int SIZE_W  = 32;
    localparam int COUNT_W = 8;
    localparam int ENTRY_W = 4;

    typedef logic [ENTRY_W-1:0] entry_idx_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SIZE_W-1:0]  size_t;

    // op codes
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_ACQUIRE  = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;
    localparam logic [1:0] OP_TICK     = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_EVICTED   = 3'd0;
    localparam logic [2:0] KIND_LOADED    = 3'd1;
    localparam logic [2:0] KIND_HIT       = 3'd2;
    localparam logic [2:0] KIND_ACK       = 3'd3;
    localparam logic [2:0] KIND_OVERSIZE  = 3'd4;
    localparam logic [2:0] KIND_NO_VICTIM = 3'd5;
    localparam logic [2:0] KIND_UNDERFLOW = 3'd6;

    localparam count_t     COUNT_MAX   = 8'hff;
    localparam logic [4:0] EVICT_LIMIT = 5'd16;

    typedef struct packed {
        logic [1:0] op;
        entry_idx_t entry_index;
        size_t      entry_size;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        entry_idx_t result_entry;
        size_t      used_total;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef struct packed {
        logic start;
        logic sample;
        logic loaded;
        logic count_zero;
    } scan_ctl_t;

endpackage

### design/size_budget_lru_cache_policy_unit.sv
`timescale 1ns / 1ps

// channel   ports                          direction  payload
// input     s_valid s_ready s_data         in         op, entry_index, entry_size
// result    m_valid m_ready m_data         out        kind, result_entry, used_total, last
// config    cfg_valid cfg_ready cfg_data   in         capacity
//
// register, release and hit items pass accept, table read and result; tick items skip the table read
// an acquire miss that does not fit runs a victim search before each eviction; each
// victim search reads the entry table once, one row per cycle on its single read port
// s_ready is high only while the sequencer is idle; a stalled result holds the sequencer
// reset is synchronous and active low; per-row valid bits make the table read as zero
// at once, so there is no clearing pass

module size_budget_lru_cache_policy_unit #(
    parameter int ENTRIES   = 16,
    parameter int TICK_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sblru_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sblru_pkg::out_item_t  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACK   = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_FIT   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_EVICT = 3'd6;

    function automatic sblru_pkg::size_t take_off(input sblru_pkg::size_t total,
                                                  input sblru_pkg::size_t sz);
        take_off = (total >= sz) ? total - sz : '0;
    endfunction

    function automatic sblru_pkg::count_t sat_inc(input sblru_pkg::count_t c);
        sat_inc = (c == sblru_pkg::COUNT_MAX) ? c : c + 1'b1;
    endfunction

    localparam int SIZE_SUM_W = sblru_pkg::SIZE_W + 1;

    logic [2:0]             state_reg, state_next;
    logic [1:0]             op_reg, op_next;
    sblru_pkg::entry_idx_t  idx_reg, idx_next;
    sblru_pkg::size_t       in_size_reg, in_size_next;
    sblru_pkg::size_t       capacity_reg;
    sblru_pkg::size_t       total_reg, total_next;
    logic [TICK_BITS-1:0]   now_reg, now_next;
    logic [ENTRIES-1:0]     loaded_reg, loaded_next;
    sblru_pkg::size_t       tgt_size_reg, tgt_size_next;
    sblru_pkg::count_t      tgt_count_reg, tgt_count_next;
    logic [TICK_BITS-1:0]   tgt_tick_reg, tgt_tick_next;
    logic [IDX_W-1:0]       scan_addr_reg, scan_addr_next;
    logic                   smp_valid_reg, smp_valid_next;
    logic [IDX_W-1:0]       smp_idx_reg, smp_idx_next;
    logic [4:0]             evict_cnt_reg, evict_cnt_next;
    logic                   m_valid_reg;
    sblru_pkg::out_item_t   m_data_reg;

    logic                   out_free;
    logic                   emit;
    sblru_pkg::out_item_t   emit_item;
    logic [IDX_W-1:0]       lidx;
    logic [SIZE_SUM_W-1:0]  fit_sum;

    sblru_pkg::mem_ctl_t    mem_ctl;
    logic [IDX_W-1:0]       wr_addr, rd_addr;
    sblru_pkg::size_t       wr_size, rd_size;
    sblru_pkg::count_t      wr_count, rd_count;
    logic [TICK_BITS-1:0]   wr_tick, rd_tick;

    sblru_pkg::scan_ctl_t   scan_ctl;
    logic                   scan_found;
    logic [IDX_W-1:0]       best_idx;
    sblru_pkg::size_t       best_size;

    sblru_entry_mem #(
        .ENTRIES   (ENTRIES),
        .TICK_BITS (TICK_BITS)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mem_ctl),
        .wr_addr  (wr_addr),
        .wr_size  (wr_size),
        .wr_count (wr_count),
        .wr_tick  (wr_tick),
        .rd_addr  (rd_addr),
        .rd_size  (rd_size),
        .rd_count (rd_count),
        .rd_tick  (rd_tick)
    );

    sblru_scan #(
        .ENTRIES   (ENTRIES),
        .TICK_BITS (TICK_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .now_ticks (now_reg),
        .smp_idx   (smp_idx_reg),
        .smp_tick  (rd_tick),
        .smp_size  (rd_size),
        .found     (scan_found),
        .best_idx  (best_idx),
        .best_size (best_size)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign lidx      = IDX_W'(idx_reg);
    assign fit_sum   = {1'b0, total_reg} + {1'b0, tgt_size_reg};

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        in_size_next   = in_size_reg;
        total_next     = total_reg;
        now_next       = now_reg;
        loaded_next    = loaded_reg;
        tgt_size_next  = tgt_size_reg;
        tgt_count_next = tgt_count_reg;
        tgt_tick_next  = tgt_tick_reg;
        scan_addr_next = scan_addr_reg;
        smp_valid_next = 1'b0;
        smp_idx_next   = smp_idx_reg;
        evict_cnt_next = evict_cnt_reg;

        emit           = 1'b0;
        emit_item      = '0;
        mem_ctl        = '0;
        wr_addr        = lidx;
        wr_size        = rd_size;
        wr_count       = rd_count;
        wr_tick        = rd_tick;
        rd_addr        = lidx;

        scan_ctl.start      = 1'b0;
        scan_ctl.sample     = smp_valid_reg;
        scan_ctl.loaded     = loaded_reg[smp_idx_reg];
        scan_ctl.count_zero = (rd_count == '0);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_data.op;
                    idx_next       = s_data.entry_index;
                    in_size_next   = s_data.entry_size;
                    evict_cnt_next = '0;
                    if (s_data.op == sblru_pkg::OP_TICK) begin
                        idx_next   = '0;
                        now_next   = now_reg + 1'b1;
                        state_next = ST_ACK;
                    end else if (32'(s_data.entry_index) >= 32'(ENTRIES)) begin
                        state_next = ST_ACK;
                    end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = IDX_W'(s_data.entry_index);
                        state_next    = ST_LOOK;
                    end
                end
            end

            ST_ACK: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_item  = '{kind: sblru_pkg::KIND_ACK, result_entry: idx_reg,
                                   used_total: total_reg, last: 1'b1};
                    state_next = ST_IDLE;
                end
            end

            ST_LOOK: begin
                tgt_size_next  = rd_size;
                tgt_count_next = rd_count;
                tgt_tick_next  = rd_tick;
                case (op_reg)
                    sblru_pkg::OP_REGISTER: begin
                        if (out_free) begin
                            if (loaded_reg[lidx]) begin
                                total_next = take_off(total_reg, rd_size);
                            end
                            loaded_next[lidx] = 1'b0;
                            mem_ctl.wr_en     = 1'b1;
                            wr_size           = in_size_reg;
                            wr_count          = '0;
                            wr_tick           = '0;
                            emit              = 1'b1;
                            emit_item         = '{kind: sblru_pkg::KIND_ACK,
                                                  result_entry: idx_reg,
                                                  used_total: total_next, last: 1'b1};
                            state_next        = ST_IDLE;
                        end
                    end
                    sblru_pkg::OP_RELEASE: begin
                        if (out_free) begin
                            mem_ctl.wr_en = 1'b1;
                            wr_count      = (rd_count == '0) ? '0 : rd_count - 1'b1;
                            wr_tick       = now_reg;
                            emit          = 1'b1;
                            emit_item     = '{kind: (rd_count == '0) ?
                                                    sblru_pkg::KIND_UNDERFLOW :
                                                    sblru_pkg::KIND_ACK,
                                              result_entry: idx_reg,
                                              used_total: total_reg, last: 1'b1};
                            state_next    = ST_IDLE;
                        end
                    end
                    default: begin
                        if (!loaded_reg[lidx]) begin
                            state_next = ST_FIT;
                        end else if (out_free) begin
                            mem_ctl.wr_en = 1'b1;
                            wr_count      = sat_inc(rd_count);
                            emit          = 1'b1;
                            emit_item     = '{kind: sblru_pkg::KIND_HIT, result_entry: idx_reg,
                                              used_total: total_reg, last: 1'b1};
                            state_next    = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_FIT: begin
                if (tgt_size_reg > capacity_reg) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_item  = '{kind: sblru_pkg::KIND_OVERSIZE, result_entry: idx_reg,
                                       used_total: total_reg, last: 1'b1};
                        state_next = ST_IDLE;
                    end
                end else if (fit_sum > {1'b0, capacity_reg}) begin
                    scan_ctl.start = 1'b1;
                    scan_addr_next = '0;
                    state_next     = ST_SCAN;
                end else if (out_free) begin
                    loaded_next[lidx] = 1'b1;
                    total_next        = fit_sum[sblru_pkg::SIZE_W-1:0];
                    mem_ctl.wr_en     = 1'b1;
                    wr_size           = tgt_size_reg;
                    wr_count          = sat_inc(tgt_count_reg);
                    wr_tick           = tgt_tick_reg;
                    emit              = 1'b1;
                    emit_item         = '{kind: sblru_pkg::KIND_LOADED, result_entry: idx_reg,
                                          used_total: total_next, last: 1'b1};
                    state_next        = ST_IDLE;
                end
            end

            ST_SCAN: begin
                // read one row per cycle, compare it in the following cycle
                mem_ctl.rd_en  = 1'b1;
                rd_addr        = scan_addr_reg;
                smp_valid_next = 1'b1;
                smp_idx_next   = scan_addr_reg;
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN: begin
                state_next = ST_EVICT;
            end

            ST_EVICT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (!scan_found || evict_cnt_reg == sblru_pkg::EVICT_LIMIT) begin
                        emit_item  = '{kind: sblru_pkg::KIND_NO_VICTIM, result_entry: idx_reg,
                                       used_total: total_reg, last: 1'b1};
                        state_next = ST_IDLE;
                    end else begin
                        loaded_next[best_idx] = 1'b0;
                        total_next            = take_off(total_reg, best_size);
                        evict_cnt_next        = evict_cnt_reg + 1'b1;
                        emit_item             = '{kind: sblru_pkg::KIND_EVICTED,
                                                  result_entry:
                                                      sblru_pkg::entry_idx_t'(best_idx),
                                                  used_total: total_next, last: 1'b0};
                        state_next            = ST_FIT;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= '0;
            total_reg     <= '0;
            now_reg       <= '0;
            loaded_reg    <= '0;
            smp_valid_reg <= 1'b0;
            evict_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            now_reg       <= now_next;
            loaded_reg    <= loaded_next;
            smp_valid_reg <= smp_valid_next;
            evict_cnt_reg <= evict_cnt_next;
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        in_size_reg   <= in_size_next;
        tgt_size_reg  <= tgt_size_next;
        tgt_count_reg <= tgt_count_next;
        tgt_tick_reg  <= tgt_tick_next;
        scan_addr_reg <= scan_addr_next;
        smp_idx_reg   <= smp_idx_next;
        if (emit) begin
            m_data_reg <= emit_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after an input transfer");

    a_victim_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVICT && scan_found) |-> loaded_reg[best_idx])
        else $error("chosen victim is not loaded");

    a_evict_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        evict_cnt_reg <= sblru_pkg::EVICT_LIMIT)
        else $error("eviction count beyond limit");

    a_evict_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == sblru_pkg::KIND_EVICTED) |-> !m_data.last)
        else $error("eviction result marked last");

    a_load_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_item.kind == sblru_pkg::KIND_LOADED) |=> loaded_reg[$past(lidx)])
        else $error("loaded entry flag not set");

endmodule

### design/sblru_entry_mem.sv
`timescale 1ns / 1ps

module sblru_entry_mem #(
    parameter int ENTRIES   = 16,
    parameter int TICK_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sblru_pkg::mem_ctl_t      ctl,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  sblru_pkg::size_t         wr_size,
    input  sblru_pkg::count_t        wr_count,
    input  logic [TICK_BITS-1:0]     wr_tick,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output sblru_pkg::size_t         rd_size,
    output sblru_pkg::count_t        rd_count,
    output logic [TICK_BITS-1:0]     rd_tick
);

    sblru_pkg::size_t     size_mem  [ENTRIES];
    sblru_pkg::count_t    count_mem [ENTRIES];
    logic [TICK_BITS-1:0] tick_mem  [ENTRIES];

    logic [ENTRIES-1:0]   row_valid_reg;
    logic                 rd_valid_reg;
    sblru_pkg::size_t     rd_size_reg;
    sblru_pkg::count_t    rd_count_reg;
    logic [TICK_BITS-1:0] rd_tick_reg;

    // a row never written reads as the reset value, zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (ctl.wr_en) begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            size_mem[wr_addr]  <= wr_size;
            count_mem[wr_addr] <= wr_count;
            tick_mem[wr_addr]  <= wr_tick;
        end
        if (ctl.rd_en) begin
            rd_size_reg  <= size_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
            rd_tick_reg  <= tick_mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rd_size  = rd_valid_reg ? rd_size_reg  : '0;
    assign rd_count = rd_valid_reg ? rd_count_reg : '0;
    assign rd_tick  = rd_valid_reg ? rd_tick_reg  : '0;

endmodule

### design/sblru_scan.sv
`timescale 1ns / 1ps

module sblru_scan #(
    parameter int ENTRIES   = 16,
    parameter int TICK_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sblru_pkg::scan_ctl_t       ctl,
    input  logic [TICK_BITS-1:0]       now_ticks,
    input  logic [$clog2(ENTRIES)-1:0] smp_idx,
    input  logic [TICK_BITS-1:0]       smp_tick,
    input  sblru_pkg::size_t           smp_size,
    output logic                       found,
    output logic [$clog2(ENTRIES)-1:0] best_idx,
    output sblru_pkg::size_t           best_size
);

    logic                       found_reg;
    logic [TICK_BITS-1:0]       best_t_reg;
    logic [$clog2(ENTRIES)-1:0] best_idx_reg;
    sblru_pkg::size_t           best_size_reg;
    logic                       take;

    // strictly older wins, so ties keep the lowest index
    assign take = ctl.sample && ctl.loaded && ctl.count_zero && (smp_tick < best_t_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            best_t_reg <= now_ticks;
        end else if (take) begin
            best_t_reg    <= smp_tick;
            best_idx_reg  <= smp_idx;
            best_size_reg <= smp_size;
        end
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_size = best_size_reg;

endmodule

### dv/tb_size_budget_lru_cache_policy_unit.sv
`timescale 1ns / 1ps

module tb_size_budget_lru_cache_policy_unit;

    localparam int N_ENTRIES  = 16;
    localparam int STALL_LIMIT = 3000;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sblru_pkg::in_item_t   s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sblru_pkg::out_item_t  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [31:0]           cfg_data  = '0;

    // request stream and expected results
    sblru_pkg::in_item_t  pending_reqs[$];
    sblru_pkg::out_item_t exp_results[$];
    int        reqs_queued   = 0;
    int        reqs_accepted = 0;
    int        fail_count    = 0;
    int        quiet_cycles  = 0;
    int        src_gap       = 0;
    int        sink_gap      = 0;
    bit        gaps_on       = 1'b1;

    // shadow of the policy state
    logic [31:0]       capacity_shadow;
    logic [31:0]       entry_size_tab[N_ENTRIES];
    bit                entry_loaded[N_ENTRIES];
    sblru_pkg::count_t entry_users[N_ENTRIES];
    logic [31:0]       entry_last_use[N_ENTRIES];
    logic [31:0]       loaded_bytes;
    logic [31:0]       tick_now;

    always #5 aclk = ~aclk;

    size_budget_lru_cache_policy_unit #(
        .ENTRIES   (N_ENTRIES),
        .TICK_BITS (32)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic void note_result(logic [2:0] kind, sblru_pkg::entry_idx_t ent,
                                        logic last);
        sblru_pkg::out_item_t r;
        r.kind         = kind;
        r.result_entry = ent;
        r.used_total   = loaded_bytes;
        r.last         = last;
        exp_results.push_back(r);
    endfunction

    function automatic void drop_bytes(logic [31:0] sz);
        loaded_bytes = (loaded_bytes >= sz) ? loaded_bytes - sz : '0;
    endfunction

    task automatic predict_policy_results(sblru_pkg::in_item_t req);
        sblru_pkg::entry_idx_t idx;
        logic [32:0] need;
        logic [31:0] oldest;
        int          victim;
        int          evicted;
        idx = req.entry_index;
        // every 4-bit index lies inside a 16-entry table
        case (req.op)
            sblru_pkg::OP_TICK: begin
                tick_now = tick_now + 32'd1;
                note_result(sblru_pkg::KIND_ACK, '0, 1'b1);
            end
            sblru_pkg::OP_REGISTER: begin
                if (entry_loaded[idx])
                    drop_bytes(entry_size_tab[idx]);
                entry_size_tab[idx] = req.entry_size;
                entry_loaded[idx]   = 1'b0;
                entry_users[idx]    = '0;
                entry_last_use[idx] = '0;
                note_result(sblru_pkg::KIND_ACK, idx, 1'b1);
            end
            sblru_pkg::OP_RELEASE: begin
                entry_last_use[idx] = tick_now;
                if (entry_users[idx] == '0) begin
                    note_result(sblru_pkg::KIND_UNDERFLOW, idx, 1'b1);
                end else begin
                    entry_users[idx] = entry_users[idx] - 8'd1;
                    note_result(sblru_pkg::KIND_ACK, idx, 1'b1);
                end
            end
            default: begin
                if (entry_loaded[idx]) begin
                    if (entry_users[idx] != sblru_pkg::COUNT_MAX)
                        entry_users[idx] = entry_users[idx] + 8'd1;
                    note_result(sblru_pkg::KIND_HIT, idx, 1'b1);
                    return;
                end
                need = {1'b0, entry_size_tab[idx]};
                if (need > {1'b0, capacity_shadow}) begin
                    note_result(sblru_pkg::KIND_OVERSIZE, idx, 1'b1);
                    return;
                end
                evicted = 0;
                while ({1'b0, loaded_bytes} + need > {1'b0, capacity_shadow}) begin
                    oldest = tick_now;
                    victim = -1;
                    // oldest unpinned entry, lowest index wins a tie
                    for (int s = 0; s < N_ENTRIES; s++) begin
                        if (entry_loaded[s] && entry_users[s] == '0 &&
                            entry_last_use[s] < oldest) begin
                            oldest = entry_last_use[s];
                            victim = s;
                        end
                    end
                    if (victim < 0 || evicted >= sblru_pkg::EVICT_LIMIT) begin
                        note_result(sblru_pkg::KIND_NO_VICTIM, idx, 1'b1);
                        return;
                    end
                    entry_loaded[victim] = 1'b0;
                    drop_bytes(entry_size_tab[victim]);
                    note_result(sblru_pkg::KIND_EVICTED, sblru_pkg::entry_idx_t'(victim), 1'b0);
                    evicted++;
                end
                if (entry_users[idx] != sblru_pkg::COUNT_MAX)
                    entry_users[idx] = entry_users[idx] + 8'd1;
                loaded_bytes      = loaded_bytes + entry_size_tab[idx];
                entry_loaded[idx] = 1'b1;
                note_result(sblru_pkg::KIND_LOADED, idx, 1'b1);
            end
        endcase
    endtask

    function automatic void queue_req(logic [1:0] op, sblru_pkg::entry_idx_t idx,
                                      logic [31:0] sz);
        sblru_pkg::in_item_t r;
        r.op          = op;
        r.entry_index = idx;
        r.entry_size  = sz;
        pending_reqs.push_back(r);
        reqs_queued++;
    endfunction

    // mostly acquire/release pairs on random entries, with loose items as noise
    task automatic queue_mixed_traffic(int n, logic [31:0] max_size);
        int                    made;
        int                    r;
        sblru_pkg::entry_idx_t e;
        logic [31:0]           sz;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            e = sblru_pkg::entry_idx_t'($urandom_range(0, N_ENTRIES - 1));
            if (r < 12) begin
                sz = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, max_size);
                queue_req(sblru_pkg::OP_REGISTER, e, sz);
                made++;
            end else if (r < 45) begin
                queue_req(sblru_pkg::OP_ACQUIRE, e, $urandom());
                if ($urandom_range(0, 1)) begin
                    queue_req(sblru_pkg::OP_TICK, sblru_pkg::entry_idx_t'($urandom()),
                              $urandom());
                    made++;
                end
                queue_req(sblru_pkg::OP_RELEASE, e, $urandom());
                made += 2;
            end else if (r < 65) begin
                queue_req(sblru_pkg::OP_ACQUIRE, e, $urandom());
                made++;
            end else if (r < 85) begin
                queue_req(sblru_pkg::OP_RELEASE, e, $urandom());
                made++;
            end else begin
                queue_req(sblru_pkg::OP_TICK, sblru_pkg::entry_idx_t'($urandom()), $urandom());
                made++;
            end
        end
    endtask

    // wait until every queued request has been taken and answered
    task automatic drain;
        while (reqs_accepted != reqs_queued || exp_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        capacity_shadow = value;
        cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_policy_results(s_data);
                reqs_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 4);
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_reqs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        sblru_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (exp_results.size() == 0) begin
                    $error("unexpected result transfer: kind %0d entry %0d",
                           m_data.kind, m_data.result_entry);
                    fail_count++;
                end else begin
                    want = exp_results.pop_front();
                    if (m_data.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_data.kind);
                        fail_count++;
                    end
                    if (m_data.result_entry !== want.result_entry) begin
                        $error("result_entry: expected %0d, got %0d",
                               want.result_entry, m_data.result_entry);
                        fail_count++;
                    end
                    if (m_data.used_total !== want.used_total) begin
                        $error("used_total: expected %0d, got %0d",
                               want.used_total, m_data.used_total);
                        fail_count++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_data.last);
                        fail_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0]           cap;
        sblru_pkg::entry_idx_t hot;
        capacity_shadow = '0;
        loaded_bytes    = '0;
        tick_now        = '0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            entry_size_tab[i] = '0;
            entry_loaded[i]   = 1'b0;
            entry_users[i]    = '0;
            entry_last_use[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // zero budget: only zero-sized entries fit
        queue_req(sblru_pkg::OP_REGISTER, 4'd0, 32'd0);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd0, 32'd0);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd0, 32'hffff_ffff);
        queue_req(sblru_pkg::OP_RELEASE,  4'd0, 32'd0);
        queue_req(sblru_pkg::OP_RELEASE,  4'd0, 32'd0);
        queue_req(sblru_pkg::OP_RELEASE,  4'd0, 32'd0);
        queue_req(sblru_pkg::OP_REGISTER, 4'd2, 32'hffff_ffff);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd2, 32'd0);
        queue_req(sblru_pkg::OP_TICK,     4'd15, 32'hffff_ffff);
        queue_req(sblru_pkg::OP_REGISTER, 4'd0, 32'd7);
        drain();

        // pinned entries block eviction, then a stamp older than now frees one
        write_capacity(32'd100);
        queue_req(sblru_pkg::OP_REGISTER, 4'd3, 32'd40);
        queue_req(sblru_pkg::OP_REGISTER, 4'd4, 32'd40);
        queue_req(sblru_pkg::OP_REGISTER, 4'd5, 32'd40);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd3, 32'd0);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd4, 32'd0);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd5, 32'd0);
        queue_req(sblru_pkg::OP_RELEASE,  4'd3, 32'd0);
        queue_req(sblru_pkg::OP_RELEASE,  4'd4, 32'd0);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd5, 32'd0);
        queue_req(sblru_pkg::OP_TICK,     4'd0, 32'd0);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd5, 32'd0);
        drain();

        // full budget with a maximum-sized entry
        write_capacity(32'hffff_ffff);
        queue_req(sblru_pkg::OP_REGISTER, 4'd7, 32'hffff_ffff);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd7, 32'd0);
        queue_req(sblru_pkg::OP_RELEASE,  4'd5, 32'd0);
        queue_req(sblru_pkg::OP_TICK,     4'd0, 32'd0);
        queue_req(sblru_pkg::OP_ACQUIRE,  4'd7, 32'd0);
        drain();

        write_capacity(32'd300);
        queue_mixed_traffic(80, 32'd120);
        drain();

        write_capacity(32'hffff_ffff);
        queue_mixed_traffic(60, 32'h2aaa_aaaa);
        // use count saturates, then comes back down
        hot = sblru_pkg::entry_idx_t'($urandom_range(0, N_ENTRIES - 1));
        queue_req(sblru_pkg::OP_REGISTER, hot, 32'd16);
        for (int i = 0; i < 258; i++)
            queue_req(sblru_pkg::OP_ACQUIRE, hot, $urandom());
        repeat (3) queue_req(sblru_pkg::OP_RELEASE, hot, $urandom());
        queue_req(sblru_pkg::OP_REGISTER, hot, $urandom_range(0, 64));
        drain();

        write_capacity(32'd0);
        queue_mixed_traffic(30, 32'd3);
        drain();

        cap = $urandom();
        write_capacity(cap);
        queue_mixed_traffic(50, cap >> 2);
        drain();

        // closing stretch without back-pressure or gaps
        gaps_on = 1'b0;
        write_capacity(32'd200);
        queue_mixed_traffic(80, 32'd90);
        drain();

        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
design/sblru_pkg.sv
design/sblru_entry_mem.sv
design/sblru_scan.sv
design/size_budget_lru_cache_policy_unit.sv
dv/tb_size_budget_lru_cache_policy_unit.sv
